// ===== hw/rtl/pli_pkg.sv =====
// shared types and constants of the piecewise linear interpolator
package pli_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned MagW  = DataW + 1;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic [1:0] REGION_INTERIOR = 2'd0;
  localparam logic [1:0] REGION_BELOW    = 2'd1;
  localparam logic [1:0] REGION_ABOVE    = 2'd2;

  // query state travelling along the cell row
  typedef struct packed {
    logic signed [DataW-1:0] q;
    logic                    last;
    logic                    found;
    logic signed [DataW-1:0] px;
    logic signed [DataW-1:0] py;
    logic signed [DataW-1:0] x0;
    logic signed [DataW-1:0] y0;
    logic signed [DataW-1:0] x1;
    logic signed [DataW-1:0] y1;
    logic signed [DataW-1:0] xf;
    logic signed [DataW-1:0] yf;
    logic signed [DataW-1:0] xl;
    logic signed [DataW-1:0] yl;
  } tok_t;

  // operands of the multiply-divide unit
  typedef struct packed {
    logic [MagW-1:0]         mag_dy;
    logic [MagW-1:0]         dx;
    logic [MagW-1:0]         den;
    logic                    neg;
    logic signed [DataW-1:0] y0;
  } md_req_t;

endpackage

// ===== hw/rtl/pli_cell.sv =====
// one breakpoint cell: holds (x, y) and updates the passing query token
module pli_cell import pli_pkg::*; #(
  parameter int unsigned K  = 0,
  parameter int unsigned IW = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [5:0]       wr_index_i,
  input  logic [DataW-1:0] wr_x_i,
  input  logic [DataW-1:0] wr_y_i,
  input  logic [IW-1:0]    last_idx_i,
  input  logic             tok_valid_i,
  input  tok_t             tok_i,
  output logic             tok_valid_o,
  output tok_t             tok_o
);

  logic signed [DataW-1:0] x_q, y_q;
  logic                    valid_q;
  tok_t                    tok_q, tok_d;
  logic                    wr_hit, in_use, is_last;

  assign wr_hit  = wr_en_i && (32'(wr_index_i) == K);
  assign in_use  = (K != 0) && (32'(last_idx_i) >= K);
  assign is_last = (32'(last_idx_i) == K);

  always_comb begin
    tok_d = tok_i;
    if (K == 0) begin
      tok_d.xf = x_q;
      tok_d.yf = y_q;
    end
    if (in_use && !tok_i.found && (tok_i.q <= x_q)) begin
      tok_d.found = 1'b1;
      tok_d.x0    = tok_i.px;
      tok_d.y0    = tok_i.py;
      tok_d.x1    = x_q;
      tok_d.y1    = y_q;
    end
    if (is_last) begin
      tok_d.xl = x_q;
      tok_d.yl = y_q;
    end
    tok_d.px = x_q;
    tok_d.py = y_q;
  end

  always_ff @(posedge clk_i) begin
    if (wr_hit) begin
      x_q <= wr_x_i;
      y_q <= wr_y_i;
    end
    tok_q <= tok_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= tok_valid_i;
    end
  end

  assign tok_valid_o = valid_q;
  assign tok_o       = tok_q;

endmodule

// ===== hw/rtl/pli_muldiv.sv =====
// serial shift-add multiply then restoring divide, one bit per cycle
module pli_muldiv import pli_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  md_req_t                 req_i,
  output logic                    done_o,
  output logic signed [DataW-1:0] result_o
);

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV
  } md_state_e;

  md_state_e               state_q;
  logic [5:0]              cnt_q;
  logic                    done_q;
  logic [MagW-1:0]         mcand_q, mpl_q, den_q;
  logic [2*MagW-1:0]       acc_q, acc_d;
  logic                    neg_q;
  logic signed [DataW-1:0] y0_q;
  logic [MagW:0]           cand, diff;
  logic                    ge;
  logic [MagW:0]           y0_ext, quo_ext, sum;

  // division step on {remainder, dividend/quotient}
  assign cand = {acc_q[2*MagW-1:MagW], acc_q[MagW-1]};
  assign diff = cand - {1'b0, den_q};
  assign ge   = !diff[MagW];

  always_comb begin
    if (state_q == MD_MUL) begin
      acc_d = {acc_q[2*MagW-2:0], 1'b0} + (mpl_q[MagW-1] ? {{MagW{1'b0}}, mcand_q} : '0);
    end else begin
      acc_d = {(ge ? diff[MagW-1:0] : cand[MagW-1:0]), acc_q[MagW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MD_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        MD_IDLE: begin
          cnt_q <= '0;
          if (start_i) begin
            state_q <= MD_MUL;
          end
        end
        MD_MUL: begin
          if (cnt_q == 6'(MagW - 1)) begin
            cnt_q   <= '0;
            state_q <= MD_DIV;
          end else begin
            cnt_q <= cnt_q + 6'd1;
          end
        end
        MD_DIV: begin
          if (cnt_q == 6'(MagW - 1)) begin
            cnt_q   <= '0;
            done_q  <= 1'b1;
            state_q <= MD_IDLE;
          end else begin
            cnt_q <= cnt_q + 6'd1;
          end
        end
        default: begin
          state_q <= MD_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == MD_IDLE) begin
      if (start_i) begin
        mcand_q <= req_i.mag_dy;
        mpl_q   <= req_i.dx;
        den_q   <= req_i.den;
        neg_q   <= req_i.neg;
        y0_q    <= req_i.y0;
        acc_q   <= '0;
      end
    end else begin
      acc_q <= acc_d;
      mpl_q <= {mpl_q[MagW-2:0], 1'b0};
    end
  end

  assign y0_ext  = {{2{y0_q[DataW-1]}}, y0_q};
  assign quo_ext = {1'b0, acc_q[MagW-1:0]};
  assign sum     = neg_q ? (y0_ext - quo_ext) : (y0_ext + quo_ext);

  assign done_o   = done_q;
  assign result_o = sum[DataW-1:0];

endmodule

// ===== hw/rtl/piecewise_linear_interpolator_core.sv =====
// top level of the piecewise linear interpolator
//
// input channel: func_i, index_i, x_value_i, y_value_i, last_query_i with
// in_valid_i / in_stall_o; an item is taken when valid is high and stall low.
// a load item writes breakpoint index_i and gives no result.
// a query item runs through the row of POINTS breakpoint cells, one cell per
// cycle, then an interior query goes through the serial multiply-divide
// unit (33 multiply steps, 33 divide steps).
// one query is in flight at a time: the input stalls from the start of a
// query until its result has reached the output register; a load leaves
// the block idle and ready for the next item.
// output channel: out_value_o, region_o, last_out_o with out_valid_o /
// out_stall_i; the result stays in the output register while stalled and the
// block takes new items as soon as its result has reached that register.
// cfg_we_i / cfg_wdata_i write point_count, saturated to 2..POINTS.
// reset clears control state and sets point_count to 2; breakpoint contents
// are undefined until loaded.
module piecewise_linear_interpolator_core import pli_pkg::*; #(
  parameter int unsigned POINTS = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [6:0]              cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    func_i,
  input  logic [5:0]              index_i,
  input  logic signed [DataW-1:0] x_value_i,
  input  logic signed [DataW-1:0] y_value_i,
  input  logic                    last_query_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [DataW-1:0] out_value_o,
  output logic [1:0]              region_o,
  output logic                    last_out_o
);

  localparam int unsigned IW = $clog2(POINTS);
  localparam int unsigned LW = ((IW > 7) ? IW : 7) + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CALC,
    ST_OUT
  } state_e;

  state_e                  state_q;
  logic [6:0]              point_count_q;
  logic [LW-1:0]           pc_ext;
  logic [IW-1:0]           last_idx;
  logic                    accept, wr_en, out_free;
  logic                    valid_chain [POINTS+1];
  tok_t                    tok_chain [POINTS+1];
  tok_t                    e;
  logic                    end_v, below, above, md_start, md_done;
  md_req_t                 md_req;
  logic signed [DataW-1:0] md_result;
  logic [MagW-1:0]         dy;
  logic signed [DataW-1:0] pend_value_q;
  logic [1:0]              pend_region_q;
  logic                    pend_last_q;
  logic                    out_valid_q;
  logic signed [DataW-1:0] out_value_q;
  logic [1:0]              out_region_q;
  logic                    out_last_q;

  assign pc_ext = LW'(point_count_q);
  always_comb begin
    if (pc_ext < LW'(2)) begin
      last_idx = IW'(1);
    end else if (pc_ext > LW'(POINTS)) begin
      last_idx = IW'(POINTS - 1);
    end else begin
      last_idx = IW'(pc_ext - LW'(1));
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign wr_en      = accept && (func_i == FUNC_LOAD);
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    tok_chain[0]      = '0;
    tok_chain[0].q    = x_value_i;
    tok_chain[0].last = last_query_i;
    valid_chain[0]    = accept && (func_i == FUNC_QUERY);
  end

  for (genvar k = 0; k < POINTS; k++) begin : g_cell
    pli_cell #(
      .K  (k),
      .IW (IW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .wr_en_i     (wr_en),
      .wr_index_i  (index_i),
      .wr_x_i      (x_value_i),
      .wr_y_i      (y_value_i),
      .last_idx_i  (last_idx),
      .tok_valid_i (valid_chain[k]),
      .tok_i       (tok_chain[k]),
      .tok_valid_o (valid_chain[k+1]),
      .tok_o       (tok_chain[k+1])
    );
  end

  assign e     = tok_chain[POINTS];
  assign end_v = valid_chain[POINTS];
  assign below = (e.q <= e.xf);
  assign above = (e.q >= e.xl);

  assign dy            = {e.y1[DataW-1], e.y1} - {e.y0[DataW-1], e.y0};
  assign md_req.mag_dy = dy[MagW-1] ? (~dy + MagW'(1)) : dy;
  assign md_req.dx     = {e.q[DataW-1], e.q} - {e.x0[DataW-1], e.x0};
  assign md_req.den    = {e.x1[DataW-1], e.x1} - {e.x0[DataW-1], e.x0};
  assign md_req.neg    = dy[MagW-1];
  assign md_req.y0     = e.y0;
  assign md_start      = (state_q == ST_SCAN) && end_v && !below && !above;

  pli_muldiv u_muldiv (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (md_start),
    .req_i    (md_req),
    .done_o   (md_done),
    .result_o (md_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      point_count_q <= 7'd2;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        point_count_q <= cfg_wdata_i;
      end
      if ((state_q == ST_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (valid_chain[0]) begin
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (end_v) begin
            state_q <= (below || above) ? ST_OUT : ST_CALC;
          end
        end
        ST_CALC: begin
          if (md_done) begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_SCAN) && end_v) begin
      pend_last_q <= e.last;
      if (below) begin
        pend_value_q  <= e.yf;
        pend_region_q <= REGION_BELOW;
      end else if (above) begin
        pend_value_q  <= e.yl;
        pend_region_q <= REGION_ABOVE;
      end else begin
        pend_region_q <= REGION_INTERIOR;
      end
    end
    if ((state_q == ST_CALC) && md_done) begin
      pend_value_q <= md_result;
    end
    if ((state_q == ST_OUT) && out_free) begin
      out_value_q  <= pend_value_q;
      out_region_q <= pend_region_q;
      out_last_q   <= pend_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign region_o    = out_region_q;
  assign last_out_o  = out_last_q;

endmodule
